FILE: src/crs_pkg.sv
`timescale 1ns / 1ps

package crs_pkg;

	// Number of rectangles the stack can hold.
	localparam int StackDepth = 32;
	// Level counter must hold StackDepth itself.
	localparam int LevelW = $clog2(StackDepth + 1);
	// Address into the rectangle store.
	localparam int AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
	// Width of the stack level field in the result word.
	localparam int StackLevelW = 6;

	// Command codes carried on the input tuser bit.
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	// One stored rectangle, 62 bits.
	typedef struct packed {
		logic [14:0] h;
		logic [14:0] w;
		logic [15:0] y;
		logic [15:0] x;
	} rect_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DONE
	} state_t;

endpackage

FILE: src/clip_rect_stack.sv
`timescale 1ns / 1ps

// Nested scissor-rectangle stack.
// The slave channel takes one command word at a time: tuser selects a push
// or a pop, and on a push tdata carries the rectangle. A push on an empty
// stack stores the rectangle as given; otherwise the rectangle is clipped
// against the current top entry, an empty overlap being stored as all zero.
// The master channel returns exactly one word per command, describing the
// active clip after it, whether clipping is on, the stack level and whether
// the command was ignored (push on a full stack, pop on an empty one).
// Each command runs in steps: the accepting edge issues the read of the
// relevant stack entry from the rectangle store, the clip edges are then
// registered, and the last step writes the store and loads the result
// register. A new command is accepted only once the previous one is done.
// The result sits in an output register, so a stalled receiver does not stop
// the next command being accepted; only if the earlier word is still
// waiting when the next result is ready does the block hold in its last step.
// Reset clears the level and the handshake state; the store needs no clear,
// as only entries below the level are ever used.
module clip_rect_stack
	import crs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: rect_x [15:0], rect_y [31:16], rect_w [46:32], rect_h [61:47]
	input  logic [63:0] s_tdata,
	// tuser: mode [0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: clip_x [15:0], clip_y [31:16], clip_w [46:32], clip_h [61:47],
	// stack_level [67:62]
	output logic [71:0] m_tdata,
	// tuser: clip_on [0], ignored [1]
	output logic [1:0]  m_tuser
);

	state_t state_q;
	state_t state_d;

	logic [LevelW-1:0] level_q;
	logic [LevelW-1:0] level_d;

	logic  mode_q;
	rect_t cmd_rect_q;

	// Rectangle store: one write port, one registered read port.
	rect_t             store_mem [StackDepth];
	rect_t             rd_data_s1;
	logic              rd_en;
	logic [AddrW-1:0]  rd_addr;
	logic              wr_en;
	logic [AddrW-1:0]  wr_addr;
	rect_t             wr_data;

	rect_t isect_rect;
	logic  isect_en;

	logic        out_free;
	logic        out_load;
	rect_t       res_rect;
	logic        res_on;
	logic        res_ignored;
	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;
	logic [1:0]  m_tuser_q;

	logic s_fire;
	logic is_full;
	logic is_empty;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign is_full  = (level_q == LevelW'(StackDepth));
	assign is_empty = (level_q == '0);
	assign out_free = !m_tvalid_q || m_tready;

	// A push reads the current top for clipping; a pop reads the entry that
	// becomes the new top. The write of a command happens in its last step,
	// well before the next read, so accesses never overlap.
	assign rd_en   = s_fire;
	assign rd_addr = (s_tuser == MODE_POP) ? AddrW'(level_q - LevelW'(2))
	                                       : AddrW'(level_q - LevelW'(1));
	assign wr_addr = AddrW'(level_q);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			mode_q     <= s_tuser;
			cmd_rect_q <= s_tdata[61:0];
		end
	end

	assign isect_en = (state_q == ST_CALC);

	crs_isect u_isect (
		.clk (clk),
		.en  (isect_en),
		.a   (cmd_rect_q),
		.b   (rd_data_s1),
		.res (isect_rect)
	);

	always_comb begin
		state_d     = state_q;
		level_d     = level_q;
		wr_en       = 1'b0;
		wr_data     = cmd_rect_q;
		out_load    = 1'b0;
		res_rect    = '0;
		res_on      = 1'b0;
		res_ignored = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (mode_q == MODE_PUSH) begin
						if (is_full) begin
							res_ignored = 1'b1;
							res_on      = 1'b1;
							res_rect    = rd_data_s1;
						end else begin
							wr_en    = 1'b1;
							wr_data  = is_empty ? cmd_rect_q : isect_rect;
							level_d  = level_q + LevelW'(1);
							res_on   = 1'b1;
							res_rect = wr_data;
						end
					end else begin
						if (is_empty) begin
							res_ignored = 1'b1;
						end else begin
							level_d = level_q - LevelW'(1);
							if (level_q != LevelW'(1)) begin
								res_on   = 1'b1;
								res_rect = rd_data_s1;
							end
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			level_q <= '0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {4'b0000, StackLevelW'(level_d), res_rect};
			m_tuser_q <= {res_ignored, res_on};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// The level can never pass the stack depth.
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LevelW'(StackDepth))
		else $error("stack level beyond depth");

	// The store is only written below the depth, on a push.
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!is_full && (mode_q == MODE_PUSH)))
		else $error("store written on full stack or pop");

	// The level moves only in the last step of a command.
	a_level_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DONE) |=> $stable(level_q))
		else $error("level changed outside the update step");

	// With clipping off the reported rectangle is all zero.
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tuser_q[0]) |-> (m_tdata_q[61:0] == '0))
		else $error("clip rectangle not zero while clipping is off");

endmodule

FILE: src/crs_isect.sv
`timescale 1ns / 1ps

// Intersects a pushed rectangle with the current top of the stack. The edges
// are registered when en is high; the final rectangle is formed from them.
module crs_isect
	import crs_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  rect_t a,
	input  rect_t b,
	output rect_t res
);

	logic signed [15:0] left_s1;
	logic signed [15:0] top_s1;
	logic signed [17:0] right_s1;
	logic signed [17:0] bottom_s1;

	logic signed [17:0] a_right;
	logic signed [17:0] b_right;
	logic signed [17:0] a_bottom;
	logic signed [17:0] b_bottom;
	logic signed [17:0] left_ext;
	logic signed [17:0] top_ext;
	logic signed [17:0] width_full;
	logic signed [17:0] height_full;

	always_comb begin
		a_right  = $signed({{2{a.x[15]}}, a.x}) + $signed({3'b000, a.w});
		b_right  = $signed({{2{b.x[15]}}, b.x}) + $signed({3'b000, b.w});
		a_bottom = $signed({{2{a.y[15]}}, a.y}) + $signed({3'b000, a.h});
		b_bottom = $signed({{2{b.y[15]}}, b.y}) + $signed({3'b000, b.h});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_s1   <= ($signed(a.x) > $signed(b.x)) ? $signed(a.x) : $signed(b.x);
			top_s1    <= ($signed(a.y) > $signed(b.y)) ? $signed(a.y) : $signed(b.y);
			right_s1  <= (a_right < b_right) ? a_right : b_right;
			bottom_s1 <= (a_bottom < b_bottom) ? a_bottom : b_bottom;
		end
	end

	always_comb begin
		left_ext    = $signed({{2{left_s1[15]}}, left_s1});
		top_ext     = $signed({{2{top_s1[15]}}, top_s1});
		width_full  = right_s1 - left_ext;
		height_full = bottom_s1 - top_ext;
		if ((left_ext >= right_s1) || (top_ext >= bottom_s1)) begin
			res = '0;
		end else begin
			res.x = left_s1;
			res.y = top_s1;
			res.w = width_full[14:0];
			res.h = height_full[14:0];
		end
	end

endmodule

FILE: dv/clip_rect_stack_tb.sv
`timescale 1ns / 1ps

module clip_rect_stack_tb;
	import crs_pkg::*;

	localparam int CycleLimit = 300000;
	localparam int DrainCycles = 20;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// tdata: rect_x [15:0], rect_y [31:16], rect_w [46:32], rect_h [61:47]
	logic [63:0] s_tdata;
	// tuser: mode [0]
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// tdata: clip_x [15:0], clip_y [31:16], clip_w [46:32], clip_h [61:47],
	// stack_level [67:62]
	logic [71:0] m_tdata;
	// tuser: clip_on [0], ignored [1]
	logic [1:0]  m_tuser;

	// One result word as the block should report it.
	typedef struct {
		logic [15:0] x;
		logic [15:0] y;
		logic [14:0] w;
		logic [14:0] h;
		logic        on;
		logic        ign;
		logic [5:0]  lvl;
	} clip_word_t;

	// Keeps its own copy of the scissor stack, works out the word that each
	// accepted command should produce and checks the returned words in order.
	class scissor_tracker;
		rect_t       rects[StackDepth];
		int unsigned depth_now;
		clip_word_t  clip_words_due[$];
		int          errors;

		function new();
			depth_now = 0;
			errors = 0;
		endfunction

		function void note_command(logic mode, rect_t r);
			clip_word_t want;
			rect_t      top;
			int         lft, tp, rgt, bot;
			want.ign = 1'b0;
			if (mode == MODE_PUSH) begin
				if (depth_now >= StackDepth) begin
					want.ign = 1'b1;
				end else begin
					// A nested push keeps only the overlap with the current top.
					if (depth_now > 0) begin
						top = rects[depth_now - 1];
						lft = int'($signed(r.x)) > int'($signed(top.x)) ?
							int'($signed(r.x)) : int'($signed(top.x));
						tp = int'($signed(r.y)) > int'($signed(top.y)) ?
							int'($signed(r.y)) : int'($signed(top.y));
						rgt = int'($signed(r.x)) + int'(r.w);
						if (int'($signed(top.x)) + int'(top.w) < rgt)
							rgt = int'($signed(top.x)) + int'(top.w);
						bot = int'($signed(r.y)) + int'(r.h);
						if (int'($signed(top.y)) + int'(top.h) < bot)
							bot = int'($signed(top.y)) + int'(top.h);
						if (lft >= rgt || tp >= bot) begin
							r = '0;
						end else begin
							r.x = 16'(lft);
							r.y = 16'(tp);
							r.w = 15'(rgt - lft);
							r.h = 15'(bot - tp);
						end
					end
					rects[depth_now] = r;
					depth_now++;
				end
			end else begin
				if (depth_now == 0)
					want.ign = 1'b1;
				else
					depth_now--;
			end
			if (depth_now > 0) begin
				top = rects[depth_now - 1];
				want.x = top.x;
				want.y = top.y;
				want.w = top.w;
				want.h = top.h;
				want.on = 1'b1;
			end else begin
				want.x = '0;
				want.y = '0;
				want.w = '0;
				want.h = '0;
				want.on = 1'b0;
			end
			want.lvl = 6'(depth_now);
			clip_words_due.push_back(want);
		endfunction

		function void compare(string field, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			end
		endfunction

		function void check_word(logic [71:0] data, logic [1:0] user);
			clip_word_t want;
			if (clip_words_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, actual data %h user %b",
					$time, data, user);
				return;
			end
			want = clip_words_due.pop_front();
			compare("clip_x", want.x, data[15:0]);
			compare("clip_y", want.y, data[31:16]);
			compare("clip_w", 16'(want.w), 16'(data[46:32]));
			compare("clip_h", 16'(want.h), 16'(data[61:47]));
			compare("stack_level", 16'(want.lvl), 16'(data[67:62]));
			compare("clip_on", 16'(want.on), 16'(user[0]));
			compare("ignored", 16'(want.ign), 16'(user[1]));
		endfunction
	endclass

	scissor_tracker tracker;
	int tx_idle_pct;
	int rx_stall_pct;
	int rx_hold_left;
	int cycle_count;

	clip_rect_stack u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: random stalls at the set rate, or a long hold-off when asked.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				m_tready <= 1'b0;
				rx_hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_word(m_tdata, m_tuser);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_cmd(input logic mode, input rect_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {2'b00, r};
		do @(posedge clk); while (!s_tready);
		tracker.note_command(mode, r);
		@(negedge clk);
	endtask

	task automatic push_rect(input int x, input int y, input int w, input int h);
		rect_t r;
		r.x = 16'(x);
		r.y = 16'(y);
		r.w = 15'(w);
		r.h = 15'(h);
		send_cmd(MODE_PUSH, r);
	endtask

	task automatic pop_rect();
		rect_t r;
		r = 62'({$urandom, $urandom});
		send_cmd(MODE_POP, r);
	endtask

	// Lower valid and hold the sender until every outstanding word is back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (tracker.clip_words_due.size() != 0)
			@(negedge clk);
	endtask

	function automatic rect_t rand_rect();
		rect_t r;
		case ($urandom_range(9))
			0, 1: r = 62'({$urandom, $urandom});
			2: begin
				r.x = $urandom_range(1) ? 16'h8000 : 16'h7fff;
				r.y = $urandom_range(1) ? 16'h8000 : 16'h7fff;
				r.w = $urandom_range(1) ? 15'h7fff : 15'h0000;
				r.h = $urandom_range(1) ? 15'h7fff : 15'h0000;
			end
			default: begin
				// Clustered near the origin so that nested overlaps are common.
				r.x = 16'($urandom_range(400) - 200);
				r.y = 16'($urandom_range(400) - 200);
				r.w = 15'($urandom_range(400));
				r.h = 15'($urandom_range(400));
			end
		endcase
		return r;
	endfunction

	// Random walk over the stack depth: each stretch has its own push bias,
	// so the stack is driven both to full and to empty.
	task automatic run_random(input int count);
		int sent;
		int stretch_left;
		int push_pct;
		sent = 0;
		stretch_left = 0;
		push_pct = 50;
		while (sent < count) begin
			if (stretch_left == 0) begin
				stretch_left = $urandom_range(120, 30);
				case ($urandom_range(4))
					0: push_pct = 97;
					1: push_pct = 75;
					2: push_pct = 50;
					3: push_pct = 25;
					default: push_pct = 10;
				endcase
			end
			if ($urandom_range(99) < push_pct)
				send_cmd(MODE_PUSH, rand_rect());
			else
				pop_rect();
			stretch_left--;
			sent++;
		end
	endtask

	initial begin
		tracker = new();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_left = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = MODE_PUSH;
		s_tdata = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty-stack pop, extremes, empty and partial overlaps.
		pop_rect();
		push_rect(-32768, -32768, 32767, 32767);
		push_rect(32767, 32767, 32767, 32767);
		pop_rect();
		push_rect(-100, -50, 300, 200);
		push_rect(-32768, 0, 0, 5);
		pop_rect();
		pop_rect();
		pop_rect();
		pop_rect();
		push_rect(0, 0, 0, 0);
		push_rect(0, 0, 10, 10);
		pop_rect();
		pop_rect();
		push_rect(32767, 32767, 32767, 32767);
		push_rect(-1, -1, 2, 2);
		pop_rect();
		pop_rect();
		push_rect(10, 10, 100, 100);
		push_rect(50, -20, 100, 50);
		push_rect(60, 15, 5, 5);
		pop_rect();
		pop_rect();
		pop_rect();
		wait_drained();

		// No idling, but the receiver first holds off long enough for the
		// block to fill up and stall its input.
		rx_hold_left = 300;
		run_random(350);
		wait_drained();

		tx_idle_pct = 79;
		rx_stall_pct = 0;
		run_random(350);
		wait_drained();

		tx_idle_pct = 0;
		rx_stall_pct = 79;
		run_random(350);
		wait_drained();

		tx_idle_pct = 12;
		rx_stall_pct = 12;
		run_random(350);
		wait_drained();

		repeat (DrainCycles) @(negedge clk);
		if (tracker.errors == 0 && tracker.clip_words_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
